[rtl/isl_pkg.sv]
// shared types, constants and the divider step for the letterbox layout pipeline
`default_nettype none

package isl_pkg;

  localparam int IslDimBits = 16;
  localparam int DimW       = 16;
  localparam int OffW       = 15;
  localparam int DivSteps   = DimW;
  localparam int InDataW    = 32;
  localparam int OutDataW   = 144;

  // configuration register indexes
  typedef enum logic {
    REG_VIRTUAL_WIDTH  = 1'b0,
    REG_VIRTUAL_HEIGHT = 1'b1
  } isl_reg_e;

  // one lane of the restoring divider
  typedef struct packed {
    logic [DimW-1:0] num;
    logic [DimW-1:0] rem;
  } isl_div_t;

  // side data through the ratio dividers
  typedef struct packed {
    logic [DimW-1:0] ww;
    logic [DimW-1:0] wh;
    logic            zero;
  } isl_side_a_t;

  // side data through the crop dividers
  typedef struct packed {
    logic [DimW-1:0] ww;
    logic [DimW-1:0] wh;
    logic [DimW-1:0] scale;
    logic            zero;
  } isl_side_b_t;

  // one quotient bit: shift in the next numerator bit, subtract if it fits
  function automatic isl_div_t div_step(isl_div_t cur, logic [DimW-1:0] dvsr);
    logic [DimW:0] trial;
    logic          ge;
    isl_div_t      nxt;
    trial   = {cur.rem, cur.num[DimW-1]};
    ge      = trial >= {1'b0, dvsr};
    nxt.rem = ge ? DimW'(trial - {1'b0, dvsr}) : trial[DimW-1:0];
    nxt.num = {cur.num[DimW-2:0], ge};
    return nxt;
  endfunction

endpackage

`default_nettype wire

[rtl/integer_scale_letterbox_layout.sv]
// Integer-scale letterbox layout: each window size transaction yields one layout transaction.
// The pipeline takes a new window size in every cycle while the result side does not stall;
// it holds two 16-step restoring dividers (window/virtual, then window/scale), one quotient
// bit per stage, followed by crop, multiply and centering stages. Any stall on the result side
// holds the whole pipeline. Virtual frame size is written over APB at address 0 (width) and 4
// (height), to be done while no transaction is in flight; the block does not enforce it.
`default_nettype none

module integer_scale_letterbox_layout import isl_pkg::*; #(
  parameter int DIMENSION_BITS = IslDimBits
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // apb configuration
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [2:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic      [31:0]         prdata,
  output logic                     pready,
  // window size in
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [InDataW-1:0]  s_axis_tdata,  // window_width, window_height
  // layout out
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic      [OutDataW-1:0] m_axis_tdata   // scale, src_x, src_y, src_width,
                                                  // src_height, dst_x, dst_y, dst_width,
                                                  // dst_height, identity, zero pad
);

  localparam logic [DimW-1:0] DimMask =
    (DIMENSION_BITS >= DimW) ? {DimW{1'b1}} : DimW'((17'(1) << DIMENSION_BITS) - 17'(1));

  logic [DimW-1:0] vw_q, vh_q, vw, vh;
  logic            en;

  assign vw = vw_q & DimMask;
  assign vh = vh_q & DimMask;

  // configuration registers
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vw_q <= '0;
      vh_q <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (isl_reg_e'(paddr[2]))
        REG_VIRTUAL_WIDTH:  vw_q <= pwdata[DimW-1:0];
        REG_VIRTUAL_HEIGHT: vh_q <= pwdata[DimW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (isl_reg_e'(paddr[2]))
      REG_VIRTUAL_WIDTH:  prdata = {16'd0, vw_q};
      REG_VIRTUAL_HEIGHT: prdata = {16'd0, vh_q};
      default:            prdata = '0;
    endcase
  end

  // whole pipeline advances together
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // ratio dividers: window / virtual
  isl_div_t    a_x_q [DivSteps+1];
  isl_div_t    a_y_q [DivSteps+1];
  isl_side_a_t a_s_q [DivSteps+1];
  logic        a_v_q [DivSteps+1];

  logic [DimW-1:0] in_ww, in_wh;
  assign in_ww = s_axis_tdata[DimW-1:0] & DimMask;
  assign in_wh = s_axis_tdata[2*DimW-1:DimW] & DimMask;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) a_v_q[0] <= 1'b0;
    else if (en) a_v_q[0] <= s_axis_tvalid;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      a_x_q[0]      <= '{num: in_ww, rem: '0};
      a_y_q[0]      <= '{num: in_wh, rem: '0};
      a_s_q[0].ww   <= in_ww;
      a_s_q[0].wh   <= in_wh;
      a_s_q[0].zero <= (in_ww == '0) || (in_wh == '0) || (vw == '0) || (vh == '0);
    end
  end

  for (genvar i = 1; i <= DivSteps; i++) begin : g_div_a
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) a_v_q[i] <= 1'b0;
      else if (en) a_v_q[i] <= a_v_q[i-1];
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        a_x_q[i] <= div_step(a_x_q[i-1], vw);
        a_y_q[i] <= div_step(a_y_q[i-1], vh);
        a_s_q[i] <= a_s_q[i-1];
      end
    end
  end

  // scale select: smaller ratio, at least one, zero for an empty dimension
  logic [DimW-1:0] qx, qy, qmin, scale_d;
  assign qx      = a_x_q[DivSteps].num;
  assign qy      = a_y_q[DivSteps].num;
  assign qmin    = (qx < qy) ? qx : qy;
  assign scale_d = a_s_q[DivSteps].zero ? '0 : ((qmin == '0) ? DimW'(1) : qmin);

  isl_div_t    b_x_q [DivSteps+1];
  isl_div_t    b_y_q [DivSteps+1];
  isl_side_b_t b_s_q [DivSteps+1];
  logic        b_v_q [DivSteps+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) b_v_q[0] <= 1'b0;
    else if (en) b_v_q[0] <= a_v_q[DivSteps];
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      b_x_q[0]       <= '{num: a_s_q[DivSteps].ww, rem: '0};
      b_y_q[0]       <= '{num: a_s_q[DivSteps].wh, rem: '0};
      b_s_q[0].ww    <= a_s_q[DivSteps].ww;
      b_s_q[0].wh    <= a_s_q[DivSteps].wh;
      b_s_q[0].scale <= scale_d;
      b_s_q[0].zero  <= a_s_q[DivSteps].zero;
    end
  end

  // crop dividers: window / scale
  for (genvar i = 1; i <= DivSteps; i++) begin : g_div_b
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) b_v_q[i] <= 1'b0;
      else if (en) b_v_q[i] <= b_v_q[i-1];
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        b_x_q[i] <= div_step(b_x_q[i-1], b_s_q[i-1].scale);
        b_y_q[i] <= div_step(b_y_q[i-1], b_s_q[i-1].scale);
        b_s_q[i] <= b_s_q[i-1];
      end
    end
  end

  // crop stage: source size and centered source offset
  logic [DimW-1:0] bqx, bqy, sw_d, sh_d;
  logic [DimW-1:0] c_sw_q, c_sh_q;
  logic [OffW-1:0] c_sx_q, c_sy_q;
  isl_side_b_t     c_s_q;
  logic            c_v_q;

  assign bqx  = b_x_q[DivSteps].num;
  assign bqy  = b_y_q[DivSteps].num;
  assign sw_d = (vw < bqx) ? vw : bqx;
  assign sh_d = (vh < bqy) ? vh : bqy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) c_v_q <= 1'b0;
    else if (en) c_v_q <= b_v_q[DivSteps];
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      c_sw_q <= sw_d;
      c_sh_q <= sh_d;
      c_sx_q <= OffW'((vw - sw_d) >> 1);
      c_sy_q <= OffW'((vh - sh_d) >> 1);
      c_s_q  <= b_s_q[DivSteps];
    end
  end

  // multiply stage: presented size
  logic [2*DimW-1:0] dw_full, dh_full;
  logic [DimW-1:0]   d_dw_q, d_dh_q, d_sw_q, d_sh_q;
  logic [OffW-1:0]   d_sx_q, d_sy_q;
  isl_side_b_t       d_s_q;
  logic              d_v_q;

  assign dw_full = c_sw_q * c_s_q.scale;
  assign dh_full = c_sh_q * c_s_q.scale;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) d_v_q <= 1'b0;
    else if (en) d_v_q <= c_v_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      d_dw_q <= dw_full[DimW-1:0];
      d_dh_q <= dh_full[DimW-1:0];
      d_sw_q <= c_sw_q;
      d_sh_q <= c_sh_q;
      d_sx_q <= c_sx_q;
      d_sy_q <= c_sy_q;
      d_s_q  <= c_s_q;
    end
  end

  // center stage and output register
  logic [OffW-1:0] dx_d, dy_d;
  logic            ident_d;
  logic [OutDataW-1:0] out_d, out_q;
  logic                out_v_q;

  assign dx_d    = OffW'((d_s_q.ww - d_dw_q) >> 1);
  assign dy_d    = OffW'((d_s_q.wh - d_dh_q) >> 1);
  assign ident_d = (d_s_q.scale == DimW'(1)) && (dx_d == '0) && (dy_d == '0) &&
                   (d_sx_q == '0) && (d_sy_q == '0) &&
                   (d_dw_q == d_s_q.ww) && (d_dh_q == d_s_q.wh);

  always_comb begin
    if (d_s_q.zero) begin
      out_d = '0;
    end else begin
      out_d = {3'b000, ident_d, d_dh_q, d_dw_q, dy_d, dx_d,
               d_sh_q, d_sw_q, d_sy_q, d_sx_q, d_s_q.scale};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (en) out_v_q <= d_v_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) out_q <= out_d;
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

  // scale leaving the select stage is at least one unless a dimension is empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_v_q[DivSteps] && !a_s_q[DivSteps].zero |-> scale_d != '0)
    else $error("scale zero for nonempty dimensions");

  // identity only at unit scale
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[140] |-> m_axis_tdata[DimW-1:0] == DimW'(1))
    else $error("identity flagged at non-unit scale");

  // presented size never exceeds the window
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    d_v_q && !d_s_q.zero |-> d_dw_q <= d_s_q.ww && d_dh_q <= d_s_q.wh)
    else $error("presented size larger than window");

  // a held result keeps the pipeline frozen
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(d_v_q) && $stable(c_v_q))
    else $error("pipeline moved during stall");

endmodule

`default_nettype wire
